/* design/cbha_pkg.sv */
package cbha_pkg;

	// Handle layout: the upper bits name a chunk, the low bits name a slot.
	localparam int SLOTS      = 32;
	localparam int SLOT_W     = 5;
	localparam int HANDLE_W   = 9;
	localparam int ID_CHUNK_W = HANDLE_W - SLOT_W;
	localparam int OP_W       = 2;
	localparam int STATUS_W   = 2;
	localparam int DATA_W     = 32;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_GET   = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	// Answer of the lowest-free-slot search.
	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] idx;
	} slot_find_t;

endpackage

/* design/cbha_slot_find.sv */
module cbha_slot_find (
	input  logic [cbha_pkg::SLOTS-1:0] occ,
	output cbha_pkg::slot_find_t       res
);
	import cbha_pkg::*;

	logic [SLOTS-1:0] free_bits;
	logic [SLOTS-1:0] lowest;

	// Isolate the lowest free slot as a one-hot word, then encode each index
	// bit as the OR of the slot positions that have that bit set.
	assign free_bits = ~occ;
	assign lowest    = free_bits & (~free_bits + SLOTS'(1));

	always_comb begin
		res.found = |free_bits;
		res.idx   = '0;
		for (int b = 0; b < SLOT_W; b++) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (((i >> b) & 1) == 1) begin
					res.idx[b] = res.idx[b] | lowest[i];
				end
			end
		end
	end

endmodule

/* design/chunked_bitmap_handle_allocator_core.sv */
// Handle allocator built from chunks of 32 slots, each chunk tracked by a
// 32-bit occupancy bitmap. A word is accepted when start is high and busy is
// low. Each word makes a read pass and then a write pass: in the accept
// cycle the occupancy, link and element memories are read, and then, with
// busy high, the block decides the outcome and writes the memories back.
// The answer appears on status, handle_out and element_out for exactly
// one cycle with done high, in the cycle after the write pass; that cycle may
// already accept the next word; none is taken while busy, a limit set by the
// read-then-write pass through the single-ported memories. The receiver
// cannot stall the block, so done must be captured when it appears. The
// memories come out of reset with undefined contents and need no clearing
// pass: a chunk's bitmap and link are written when the chunk opens, and an
// element is only returned from a slot whose occupancy bit is set.
module chunked_bitmap_handle_allocator_core #(
	parameter int MAX_CHUNKS    = 16,
	parameter int ELEMENT_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [cbha_pkg::OP_W-1:0]       operation,
	input  logic [cbha_pkg::HANDLE_W-1:0]   request_id,
	input  logic [cbha_pkg::DATA_W-1:0]     element_value,
	output logic                            done,
	output logic [cbha_pkg::STATUS_W-1:0]   status,
	output logic [cbha_pkg::HANDLE_W-1:0]   handle_out,
	output logic [cbha_pkg::DATA_W-1:0]     element_out
);
	import cbha_pkg::*;

	// Chunk index width, width of the open-chunk counter (it must hold
	// MAX_CHUNKS itself), element memory address width, and a compare width
	// wide enough for both a chunk taken from a handle and the counter.
	localparam int CW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
	localparam int OW = $clog2(MAX_CHUNKS + 1);
	localparam int AW = CW + SLOT_W;
	localparam int VW = (OW > ID_CHUNK_W) ? OW : ID_CHUNK_W;
	localparam int EW = ELEMENT_WIDTH;
	localparam int DEPTH = MAX_CHUNKS * SLOTS;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;

	// Free-chunk list head and the count of chunks opened so far.
	logic [CW-1:0] head_q;
	logic          head_vld_q;
	logic [OW-1:0] opened_q;

	// The word being worked on.
	logic [OP_W-1:0]     op_q;
	logic [HANDLE_W-1:0] id_q;
	logic [EW-1:0]       val_q;

	// Result registers.
	logic                done_q;
	logic [STATUS_W-1:0] status_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [DATA_W-1:0]   element_q;

	// Memories. A link entry carries a valid bit above the chunk index, in
	// place of a null pointer.
	logic [SLOTS-1:0] occ_mem  [MAX_CHUNKS];
	logic [CW:0]      link_mem [MAX_CHUNKS];
	logic [EW-1:0]    elem_mem [DEPTH];

	logic [SLOTS-1:0] occ_rd_q;
	logic [CW:0]      link_rd_q;
	logic [EW-1:0]    elem_rd_q;

	logic accept;
	logic [CW-1:0] in_chunk;
	logic [CW-1:0] occ_ra;
	logic [AW-1:0] elem_ra;

	logic             occ_we;
	logic [CW-1:0]    occ_wa;
	logic [SLOTS-1:0] occ_wd;
	logic             link_we;
	logic [CW-1:0]    link_wa;
	logic [CW:0]      link_wd;
	logic             elem_we;
	logic [AW-1:0]    elem_wa;
	logic [EW-1:0]    elem_wd;

	logic [STATUS_W-1:0] nx_status;
	logic [HANDLE_W-1:0] nx_handle;
	logic [DATA_W-1:0]   nx_element;
	logic [CW-1:0]       nx_head;
	logic                nx_head_vld;
	logic                open_chunk;

	logic [ID_CHUNK_W-1:0] id_chunk;
	logic [SLOT_W-1:0]     id_slot;
	logic [CW-1:0]         id_c;
	logic                  id_open;
	logic                  id_hit;
	logic [SLOTS-1:0]      id_bit;
	logic [SLOTS-1:0]      alloc_occ;
	logic [CW-1:0]         new_c;
	slot_find_t            find;

	assign busy   = (state_q == S_EXEC);
	assign accept = start & ~busy;

	assign done        = done_q;
	assign status      = status_q;
	assign handle_out  = handle_q;
	assign element_out = element_q;

	// Read addresses come straight from the request in the accept cycle. An
	// allocate looks at the chunk on top of the free list; free and get look
	// at the chunk and slot named by the handle.
	assign in_chunk = CW'(request_id[HANDLE_W-1 -: ID_CHUNK_W]);
	assign occ_ra   = (operation == OP_ALLOC) ? head_q : in_chunk;
	assign elem_ra  = {in_chunk, request_id[SLOT_W-1:0]};

	always_ff @(posedge clk) begin
		if (occ_we) begin
			occ_mem[occ_wa] <= occ_wd;
		end
		if (accept) begin
			occ_rd_q <= occ_mem[occ_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
		if (accept) begin
			link_rd_q <= link_mem[head_q];
		end
	end

	always_ff @(posedge clk) begin
		if (elem_we) begin
			elem_mem[elem_wa] <= elem_wd;
		end
		if (accept) begin
			elem_rd_q <= elem_mem[elem_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= operation;
			id_q  <= request_id;
			val_q <= EW'(element_value);
		end
	end

	cbha_slot_find u_slot_find (
		.occ (occ_rd_q),
		.res (find)
	);

	// Handle checks for free and get: the chunk must be open and the slot
	// must be occupied.
	assign id_chunk  = id_q[HANDLE_W-1 -: ID_CHUNK_W];
	assign id_slot   = id_q[SLOT_W-1:0];
	assign id_c      = CW'(id_chunk);
	assign id_open   = VW'(id_chunk) < VW'(opened_q);
	assign id_bit    = SLOTS'(1) << id_slot;
	assign id_hit    = id_open & occ_rd_q[id_slot];
	assign alloc_occ = occ_rd_q | (SLOTS'(1) << find.idx);
	assign new_c     = CW'(opened_q);

	always_comb begin
		nx_status   = ST_INVALID;
		nx_handle   = id_q;
		nx_element  = '0;
		nx_head     = head_q;
		nx_head_vld = head_vld_q;
		open_chunk  = 1'b0;
		occ_we      = 1'b0;
		occ_wa      = id_c;
		occ_wd      = occ_rd_q & ~id_bit;
		link_we     = 1'b0;
		link_wa     = id_c;
		link_wd     = {head_vld_q, head_q};
		elem_we     = 1'b0;
		elem_wa     = {head_q, find.idx};
		elem_wd     = val_q;

		if (state_q == S_EXEC) begin
			unique case (op_q)
				OP_ALLOC: begin
					if (head_vld_q) begin
						// Take the lowest free slot of the chunk at the list head.
						if (find.found) begin
							occ_we    = 1'b1;
							occ_wa    = head_q;
							occ_wd    = alloc_occ;
							elem_we   = 1'b1;
							nx_handle = HANDLE_W'({head_q, find.idx});
							nx_status = ST_OK;
							// A chunk that just filled leaves the list.
							if (&alloc_occ) begin
								nx_head     = link_rd_q[CW-1:0];
								nx_head_vld = link_rd_q[CW];
							end
						end else begin
							nx_status = ST_FULL;
						end
					end else if (opened_q < OW'(MAX_CHUNKS)) begin
						// Empty list: open a new chunk, fill its first slot and
						// push it on the list.
						open_chunk  = 1'b1;
						occ_we      = 1'b1;
						occ_wa      = new_c;
						occ_wd      = SLOTS'(1);
						elem_we     = 1'b1;
						elem_wa     = {new_c, SLOT_W'(0)};
						link_we     = 1'b1;
						link_wa     = new_c;
						nx_head     = new_c;
						nx_head_vld = 1'b1;
						nx_handle   = HANDLE_W'({new_c, SLOT_W'(0)});
						nx_status   = ST_OK;
					end else begin
						nx_status = ST_FULL;
					end
				end
				OP_FREE: begin
					if (id_hit) begin
						nx_element = DATA_W'(elem_rd_q);
						nx_status  = ST_OK;
						occ_we     = 1'b1;
						// A formerly full chunk goes back on top of the list.
						if (&occ_rd_q) begin
							link_we     = 1'b1;
							nx_head     = id_c;
							nx_head_vld = 1'b1;
						end
					end
				end
				OP_GET: begin
					if (id_hit) begin
						nx_element = DATA_W'(elem_rd_q);
						nx_status  = ST_OK;
					end
				end
				default: begin
					nx_status = ST_INVALID;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			head_q     <= '0;
			head_vld_q <= 1'b0;
			opened_q   <= '0;
			done_q     <= 1'b0;
			status_q   <= '0;
			handle_q   <= '0;
			element_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q    <= S_IDLE;
					head_q     <= nx_head;
					head_vld_q <= nx_head_vld;
					if (open_chunk) begin
						opened_q <= opened_q + OW'(1);
					end
					done_q    <= 1'b1;
					status_q  <= nx_status;
					handle_q  <= nx_handle;
					element_q <= nx_element;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
